// ===== src/fdsrc_pkg.sv =====
// ----------------------------------------------------------------------------
// fdsrc_pkg: shared types and constants of the flow data set record counter
// Command and result structs, walk phases and status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package fdsrc_pkg;

  localparam int MAX_FIELDS = 64;
  localparam int FT_W  = $clog2(MAX_FIELDS + 1);
  localparam int AW    = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int MRB_W = 16 + AW;

  localparam logic [15:0] VAR_LENGTH  = 16'hFFFF;
  localparam logic [7:0]  LONG_ESCAPE = 8'd255;
  localparam logic [15:0] PAD_LIMIT   = 16'd3;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_START  = 2'd2,
    CMD_BYTE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TRUNC_PFX  = 3'd1,
    ST_TRUNC_REC  = 3'd2,
    ST_BAD_PAD    = 3'd3,
    ST_EMPTY_TPL  = 3'd4,
    ST_OVERFLOW   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SKIP    = 3'd1,
    PH_PREFIX  = 3'd2,
    PH_LONG_HI = 3'd3,
    PH_LONG_LO = 3'd4,
    PH_DRAIN   = 3'd5,
    PH_RUN     = 3'd6
  } phase_e;

  typedef struct packed {
    cmd_e        command;
    logic [15:0] fld_len;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] min_count;
    logic [15:0] max_count;
  } result_t;

  // classified request between front and walker
  typedef struct packed {
    cmd_e        kind;
    logic        var_len;
    logic        escape;
    logic [15:0] fld_len;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } req_t;

endpackage
`default_nettype wire

// ===== src/fdsrc_ram.sv =====
// ----------------------------------------------------------------------------
// fdsrc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (read-old).
// ----------------------------------------------------------------------------
`default_nettype none
module fdsrc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire                                         clk_i,
  input  wire                                         we_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]                            wdata_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/fdsrc_front.sv =====
// ----------------------------------------------------------------------------
// fdsrc_front: input side of the record counter
// Accepts items, tags variable lengths and escapes, and holds them in a
// two-entry queue for the walker.
// ----------------------------------------------------------------------------
`default_nettype none
module fdsrc_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push,
  output logic                 full,
  input  fdsrc_pkg::item_t     item_i,
  output logic                 req_valid_o,
  output fdsrc_pkg::req_t      req_o,
  input  wire                  req_take_i
);
  import fdsrc_pkg::*;

  req_t       slot_q [2];
  logic [1:0] count_q;
  logic       wr_q, rd_q;
  logic       accept;
  req_t       cls;

  always_comb begin
    cls.kind           = item_i.command;
    cls.var_len        = (item_i.fld_len == VAR_LENGTH);
    cls.escape         = (item_i.data_byte == LONG_ESCAPE);
    cls.fld_len        = item_i.fld_len;
    cls.payload_length = item_i.payload_length;
    cls.data_byte      = item_i.data_byte;
  end

  assign full        = (count_q == 2'd2);
  assign accept      = push && !full;
  assign req_valid_o = (count_q != 2'd0);
  assign req_o       = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      if (accept) wr_q <= ~wr_q;
      if (req_take_i) rd_q <= ~rd_q;
      count_q <= count_q + {1'b0, accept} - {1'b0, req_take_i};
    end
  end
endmodule
`default_nettype wire

// ===== src/fdsrc_outq.sv =====
// ----------------------------------------------------------------------------
// fdsrc_outq: result queue
// Two-entry queue that parts the walker from the result receiver.
// ----------------------------------------------------------------------------
`default_nettype none
module fdsrc_outq (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  wr_i,
  input  fdsrc_pkg::result_t   res_i,
  output logic                 room_o,
  output logic                 empty,
  input  wire                  pop,
  output fdsrc_pkg::result_t   res_o
);
  import fdsrc_pkg::*;

  result_t    slot_q [2];
  logic [1:0] count_q;
  logic       wr_q, rd_q;
  logic       rd;

  assign room_o = (count_q != 2'd2);
  assign empty  = (count_q == 2'd0);
  assign rd     = pop && !empty;
  assign res_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slot_q[wr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      if (wr_i) wr_q <= ~wr_q;
      if (rd) rd_q <= ~rd_q;
      count_q <= count_q + {1'b0, wr_i} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

// ===== src/fdsrc_walker.sv =====
// ----------------------------------------------------------------------------
// fdsrc_walker: template store and record walker
// Keeps the field template and walks the payload bytes of one data set,
// stepping through zero-length fields and record ends one per cycle while the result queue has room.
// ----------------------------------------------------------------------------
`default_nettype none
module fdsrc_walker (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  req_valid_i,
  input  fdsrc_pkg::req_t      req_i,
  output logic                 req_take_o,
  input  wire                  room_i,
  output logic                 res_wr_o,
  output fdsrc_pkg::result_t   res_o
);
  import fdsrc_pkg::*;

  phase_e           phase_q, phase_d;
  logic [FT_W-1:0]  total_q, total_d, pos_q, pos_d;
  logic             ovf_q, ovf_d, seen_q, seen_d;
  logic [MRB_W-1:0] minb_q, minb_d;
  logic [15:0]      bytes_q, bytes_d, fbl_q, fbl_d;
  logic [15:0]      rec_q, rec_d, first_q, first_d, last_q, last_d;
  logic [7:0]       hi_q, hi_d;

  logic             ram_we;
  logic [15:0]      ram_rdata;
  logic             run;
  logic [15:0]      tlen;
  logic [15:0]      rec_inc;

  assign run = (phase_q == PH_RUN) && room_i;

  always_comb begin
    phase_d  = phase_q;
    total_d  = total_q;
    pos_d    = pos_q;
    ovf_d    = ovf_q;
    seen_d   = seen_q;
    minb_d   = minb_q;
    bytes_d  = bytes_q;
    fbl_d    = fbl_q;
    rec_d    = rec_q;
    first_d  = first_q;
    last_d   = last_q;
    hi_d     = hi_q;
    ram_we   = 1'b0;
    res_wr_o = 1'b0;
    res_o    = '{status: ST_OK, min_count: 16'd0, max_count: 16'd0};
    tlen     = 16'd0;
    rec_inc  = rec_q + 16'd1;
    req_take_o = req_valid_i && room_i && (phase_q != PH_RUN);

    if (run) begin
      if (pos_q < total_q) begin
        if (ram_rdata == VAR_LENGTH) begin
          if (bytes_q == 16'd0) begin
            phase_d = PH_DRAIN;
            fbl_d   = seen_q ? 16'd0 : 16'(ST_TRUNC_PFX);
          end else begin
            phase_d = PH_PREFIX;
          end
        end else if (ram_rdata > bytes_q) begin
          phase_d = PH_DRAIN;
          fbl_d   = seen_q ? 16'd0 : 16'(ST_TRUNC_REC);
        end else if (ram_rdata != 16'd0) begin
          fbl_d   = ram_rdata;
          phase_d = PH_SKIP;
        end else begin
          pos_d = pos_q + FT_W'(1);
        end
      end else begin
        // record complete
        rec_d = rec_inc;
        if (bytes_q <= PAD_LIMIT) begin
          if (!seen_q) first_d = rec_inc;
          seen_d = 1'b1;
          last_d = rec_inc;
        end
        if (MRB_W'(bytes_q) < minb_q) begin
          phase_d = PH_DRAIN;
          fbl_d   = seen_d ? 16'd0 : 16'(ST_BAD_PAD);
        end else begin
          pos_d = '0;
        end
      end
    end else if (req_take_o) begin
      unique case (req_i.kind)
        CMD_CLEAR: begin
          total_d = '0;
          minb_d  = '0;
          ovf_d   = 1'b0;
          phase_d = PH_IDLE;
        end
        CMD_APPEND: begin
          phase_d = PH_IDLE;
          if (total_q == FT_W'(MAX_FIELDS)) begin
            ovf_d = 1'b1;
          end else begin
            ram_we  = 1'b1;
            total_d = total_q + FT_W'(1);
            minb_d  = minb_q + (req_i.var_len ? MRB_W'(1) : MRB_W'(req_i.fld_len));
          end
        end
        CMD_START: begin
          phase_d = PH_IDLE;
          if (ovf_q || total_q == '0 || minb_q == '0) begin
            res_wr_o = 1'b1;
            res_o.status = ovf_q ? ST_OVERFLOW : ST_EMPTY_TPL;
          end else begin
            bytes_d = req_i.payload_length;
            rec_d   = 16'd0;
            first_d = 16'd0;
            last_d  = 16'd0;
            seen_d  = (req_i.payload_length <= PAD_LIMIT);
            if (MRB_W'(req_i.payload_length) < minb_q) begin
              phase_d = PH_DRAIN;
              fbl_d   = seen_d ? 16'd0 : 16'(ST_BAD_PAD);
            end else begin
              pos_d   = '0;
              phase_d = PH_RUN;
            end
          end
        end
        CMD_BYTE: begin
          if (phase_q != PH_IDLE && bytes_q != 16'd0) begin
            bytes_d = bytes_q - 16'd1;
            case (phase_q)
              PH_SKIP: begin
                fbl_d = fbl_q - 16'd1;
                if (fbl_q == 16'd1) begin
                  pos_d   = pos_q + FT_W'(1);
                  phase_d = PH_RUN;
                end
              end
              PH_PREFIX: begin
                if (!req_i.escape) begin
                  tlen = {8'd0, req_i.data_byte};
                end else if (bytes_d < 16'd2) begin
                  phase_d = PH_DRAIN;
                  fbl_d   = seen_q ? 16'd0 : 16'(ST_TRUNC_PFX);
                end else begin
                  phase_d = PH_LONG_HI;
                end
              end
              PH_LONG_HI: begin
                hi_d    = req_i.data_byte;
                phase_d = PH_LONG_LO;
              end
              PH_LONG_LO: begin
                tlen = {hi_q, req_i.data_byte};
              end
              default: begin
              end
            endcase
            // take the field length just read from a prefix
            if ((phase_q == PH_PREFIX && !req_i.escape) || phase_q == PH_LONG_LO) begin
              if (tlen > bytes_d) begin
                phase_d = PH_DRAIN;
                fbl_d   = seen_q ? 16'd0 : 16'(ST_TRUNC_REC);
              end else if (tlen == 16'd0) begin
                pos_d   = pos_q + FT_W'(1);
                phase_d = PH_RUN;
              end else begin
                fbl_d   = tlen;
                phase_d = PH_SKIP;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (phase_d == PH_DRAIN && bytes_d == 16'd0 && (run || req_take_o)) begin
      res_wr_o = 1'b1;
      res_o.status = status_e'(fbl_d[2:0]);
      res_o.min_count = (fbl_d[2:0] == 3'(ST_OK)) ? first_d : 16'd0;
      res_o.max_count = (fbl_d[2:0] == 3'(ST_OK)) ? last_d : 16'd0;
      phase_d = PH_IDLE;
    end
  end

  fdsrc_ram #(
    .WIDTH(16),
    .DEPTH(MAX_FIELDS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(total_q[AW-1:0]),
    .wdata_i(req_i.fld_len),
    .raddr_i(pos_d[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      total_q <= '0;
      pos_q   <= '0;
      ovf_q   <= 1'b0;
      seen_q  <= 1'b0;
      minb_q  <= '0;
      bytes_q <= 16'd0;
      fbl_q   <= 16'd0;
      rec_q   <= 16'd0;
      first_q <= 16'd0;
      last_q  <= 16'd0;
      hi_q    <= 8'd0;
    end else begin
      phase_q <= phase_d;
      total_q <= total_d;
      pos_q   <= pos_d;
      ovf_q   <= ovf_d;
      seen_q  <= seen_d;
      minb_q  <= minb_d;
      bytes_q <= bytes_d;
      fbl_q   <= fbl_d;
      rec_q   <= rec_d;
      first_q <= first_d;
      last_q  <= last_d;
      hi_q    <= hi_d;
    end
  end

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_wr_o |-> room_i) else $error("result written without queue room");
  a_run_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RUN) |-> !req_take_o) else $error("request taken during walk");
  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP) |-> (fbl_q != 16'd0)) else $error("skip with no bytes");
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RUN) |-> (pos_q <= total_q)) else $error("field position past template");
endmodule
`default_nettype wire

// ===== src/flow_data_set_record_counter.sv =====
// ----------------------------------------------------------------------------
// flow_data_set_record_counter: counts whole records of a flow data set
// Template of field lengths plus a byte walker reporting boundary counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: push / full with item_i (command, field length,
//   payload_length, data_byte). Commands clear or append to the template,
//   start a set, or carry one payload byte.
//   Result queue: empty / pop with res_o (status, min_count, max_count);
//   at most one result per data set, or per rejected start.
//   Throughput: one request per cycle while the walker waits for bytes and
//   the result queue has room. The walker reads one template entry per
//   cycle from the field table RAM, so each walked start, each finished or
//   zero-length field and each record end takes a walker step in which no
//   request is taken. A result is written into the result queue by the
//   request that ends the set or by the walker step that ends it.
//   Reset clears all control state; the field table itself is not cleared
//   and only entries below the field count are ever used.
//   When the receiver stalls, results collect in a two-entry queue; once
//   it is full the walker holds and the input queue fills, raising full.
// ----------------------------------------------------------------------------
`default_nettype none
module flow_data_set_record_counter (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push,
  output logic                 full,
  input  fdsrc_pkg::item_t     item_i,
  output logic                 empty,
  input  wire                  pop,
  output fdsrc_pkg::result_t   res_o
);
  import fdsrc_pkg::*;

  logic    req_valid, req_take, room, res_wr;
  req_t    req;
  result_t res;

  fdsrc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .req_valid_o(req_valid),
    .req_o      (req),
    .req_take_i (req_take)
  );

  fdsrc_walker u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_i      (req),
    .req_take_o (req_take),
    .room_i     (room),
    .res_wr_o   (res_wr),
    .res_o      (res)
  );

  fdsrc_outq u_outq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .wr_i  (res_wr),
    .res_i (res),
    .room_o(room),
    .empty (empty),
    .pop   (pop),
    .res_o (res_o)
  );
endmodule
`default_nettype wire
